// ----- hw/rtl/free_interval_set_top_defines.svh -----
// Assertion macros shared by the free interval set RTL.
`ifndef FREE_INTERVAL_SET_TOP_DEFINES_SVH
`define FREE_INTERVAL_SET_TOP_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define FIS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("free interval set check failed");

// Checks that a condition holds in the cycle after its trigger.
`define FIS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("free interval set check failed");

`endif

// ----- hw/rtl/fis_pkg.sv -----
// Types and constants of the free interval set.
package fis_pkg;
	localparam int MAX_INTERVALS = 64;
	localparam int IDX_W = $clog2(MAX_INTERVALS);
	localparam int CNT_W = IDX_W + 1;
	localparam int ROOM_W = CNT_W + 1;
	localparam int MIN_W = 11;
	localparam int MINUTE_CAP = 1440;
	localparam int RST_WINDOW_START = 510;
	localparam int RST_WINDOW_END = 960;
	localparam int RST_MIN_FIT = 25;

	localparam logic [1:0] REQ_INIT = 2'd0;
	localparam logic [1:0] REQ_CLAIM = 2'd1;
	localparam logic [1:0] REQ_SUB = 2'd2;
	localparam logic [1:0] REQ_QUERY = 2'd3;

	localparam logic [1:0] CFG_WINDOW_START = 2'd0;
	localparam logic [1:0] CFG_WINDOW_END = 2'd1;
	localparam logic [1:0] CFG_MIN_FIT = 2'd2;

	typedef struct packed {
		logic [MIN_W-1:0] ivl_start;
		logic [MIN_W-1:0] ivl_stop;
	} entry_t;

	typedef enum logic [2:0] {
		ST_BOOT,
		ST_IDLE,
		ST_RUN,
		ST_SPLIT2,
		ST_FINISH
	} state_t;
endpackage

// ----- hw/rtl/fis_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- hw/rtl/free_interval_set_top.sv -----
// Free interval set top level: a sorted table of free intervals in two RAM banks.
// Init, an empty table and a claim or subtract with an empty range go straight to FINISH;
// other requests stream the held intervals through the RUN state, with an extra SPLIT2 step
// per split, and a query stops at the first entry that fits. A new beat can be taken in the
// cycle in which out_valid rises; a finished result waits while the earlier one still stalls.
// One RAM read port streams one interval per cycle unless a split holds it. Reset loads the default window in BOOT.
module free_interval_set_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [fis_pkg::MIN_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 req_type,
	input  logic [fis_pkg::MIN_W-1:0]  range_start,
	input  logic [fis_pkg::MIN_W-1:0]  range_end,
	input  logic [fis_pkg::MIN_W-1:0]  claim_length,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       claim_ok,
	output logic                       fit_found,
	output logic [fis_pkg::MIN_W-1:0]  fit_start,
	output logic [fis_pkg::MIN_W-1:0]  fit_end,
	output logic                       table_full,
	output logic [fis_pkg::CNT_W-1:0]  interval_count
);
	import fis_pkg::*;
`include "free_interval_set_top_defines.svh"

	state_t state_q, state_d;

	logic [MIN_W-1:0] window_start_q, window_end_q, min_fit_q;
	logic [1:0] req_q;
	logic [MIN_W-1:0] s_q, e_q, len_q;
	logic [CNT_W-1:0] cnt_q, n_q, rd_idx_q, wr_idx_q, proc_idx_s1;
	logic proc_valid_s1;
	logic bank_q, ran_q, claimed_q, ok_q, full_q, found_q;
	logic [MIN_W-1:0] fstart_q, fend_q;
	entry_t pend_q;

	logic accept, issue, flip;
	logic [1:0] ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t ram_wdata, rdata0, rdata1, ent, wr_ent;
	logic [MIN_W-1:0] a, b;
	logic wr_en, split, set_ok, set_full, set_claimed, fit_hit, room, window_ok;
	logic [MIN_W:0] sum;
	logic [MIN_W-1:0] fend_sat;
	logic [CNT_W-1:0] cnt_next;

	assign accept = in_valid && !in_stall;
	assign ent = bank_q ? rdata1 : rdata0;
	assign a = ent.ivl_start;
	assign b = ent.ivl_stop;
	assign window_ok = window_start_q < window_end_q;
	assign room = ({1'b0, wr_idx_q} + {1'b0, n_q} - {1'b0, proc_idx_s1})
		< ROOM_W'(MAX_INTERVALS);
	assign sum = {1'b0, a} + {1'b0, len_q};
	assign fend_sat = (sum > (MIN_W + 1)'(MINUTE_CAP)) ? MIN_W'(MINUTE_CAP) : sum[MIN_W-1:0];
	assign flip = ran_q && (req_q == REQ_CLAIM || req_q == REQ_SUB);
	assign cnt_next = flip ? wr_idx_q : cnt_q;

	fis_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_INTERVALS)) u_bank0 (
		.clk(clk), .we(ram_we[0]), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(rd_idx_q[IDX_W-1:0]), .rdata(rdata0)
	);

	fis_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_INTERVALS)) u_bank1 (
		.clk(clk), .we(ram_we[1]), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(rd_idx_q[IDX_W-1:0]), .rdata(rdata1)
	);

	// Per-interval decision of the streaming pass.
	always_comb begin
		wr_en = 1'b0;
		wr_ent = ent;
		split = 1'b0;
		set_ok = 1'b0;
		set_full = 1'b0;
		set_claimed = 1'b0;
		fit_hit = 1'b0;
		if (state_q == ST_SPLIT2) begin
			wr_en = 1'b1;
			wr_ent = pend_q;
		end else if (state_q == ST_RUN && proc_valid_s1) begin
			case (req_q)
				REQ_CLAIM: begin
					if (!claimed_q && a <= s_q && e_q <= b) begin
						set_claimed = 1'b1;
						if (a == s_q && b == e_q) begin
							set_ok = 1'b1;
						end else if (a == s_q) begin
							wr_en = 1'b1;
							wr_ent = '{ivl_start: e_q, ivl_stop: b};
							set_ok = 1'b1;
						end else if (b == e_q) begin
							wr_en = 1'b1;
							wr_ent = '{ivl_start: a, ivl_stop: s_q};
							set_ok = 1'b1;
						end else if (room) begin
							wr_en = 1'b1;
							wr_ent = '{ivl_start: a, ivl_stop: s_q};
							split = 1'b1;
							set_ok = 1'b1;
						end else begin
							wr_en = 1'b1;
							set_full = 1'b1;
						end
					end else begin
						wr_en = 1'b1;
					end
				end
				REQ_SUB: begin
					if (a < e_q && s_q < b) begin
						if (s_q <= a && b <= e_q) begin
							wr_en = 1'b0;
						end else if (s_q <= a) begin
							wr_en = 1'b1;
							wr_ent = '{ivl_start: e_q, ivl_stop: b};
						end else if (b <= e_q) begin
							wr_en = 1'b1;
							wr_ent = '{ivl_start: a, ivl_stop: s_q};
						end else if (room) begin
							wr_en = 1'b1;
							wr_ent = '{ivl_start: a, ivl_stop: s_q};
							split = 1'b1;
						end else begin
							wr_en = 1'b1;
							set_full = 1'b1;
						end
					end else begin
						wr_en = 1'b1;
					end
				end
				REQ_QUERY: begin
					fit_hit = (b - a) >= min_fit_q;
				end
				default: begin
					fit_hit = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_BOOT: state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_INIT || cnt_q == '0
						|| (req_type != REQ_QUERY && !(range_start < range_end))) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (fit_hit) begin
					state_d = ST_FINISH;
				end else if (split) begin
					state_d = ST_SPLIT2;
				end else if (!proc_valid_s1 && rd_idx_q == n_q) begin
					state_d = ST_FINISH;
				end
			end
			ST_SPLIT2: state_d = ST_RUN;
			ST_FINISH: begin
				if (!out_valid || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		issue = ((state_q == ST_RUN && !split) || state_q == ST_SPLIT2) && (rd_idx_q < n_q);
		ram_we = 2'b00;
		ram_waddr = wr_idx_q[IDX_W-1:0];
		ram_wdata = wr_ent;
		if (state_q == ST_BOOT) begin
			ram_we[0] = 1'b1;
			ram_waddr = '0;
			ram_wdata = '{ivl_start: MIN_W'(RST_WINDOW_START), ivl_stop: MIN_W'(RST_WINDOW_END)};
		end else if (accept && req_type == REQ_INIT) begin
			ram_we[bank_q] = window_ok;
			ram_waddr = '0;
			ram_wdata = '{ivl_start: window_start_q, ivl_stop: window_end_q};
		end else if (wr_en) begin
			ram_we[!bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BOOT;
			window_start_q <= MIN_W'(RST_WINDOW_START);
			window_end_q <= MIN_W'(RST_WINDOW_END);
			min_fit_q <= MIN_W'(RST_MIN_FIT);
			cnt_q <= CNT_W'(RST_WINDOW_START < RST_WINDOW_END);
			bank_q <= 1'b0;
			out_valid <= 1'b0;
			proc_valid_s1 <= 1'b0;
			proc_idx_s1 <= '0;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			n_q <= '0;
			ran_q <= 1'b0;
			claimed_q <= 1'b0;
			ok_q <= 1'b0;
			full_q <= 1'b0;
			found_q <= 1'b0;
			fstart_q <= '0;
			fend_q <= '0;
			pend_q <= '0;
			req_q <= REQ_INIT;
			s_q <= '0;
			e_q <= '0;
			len_q <= '0;
			claim_ok <= 1'b0;
			fit_found <= 1'b0;
			fit_start <= '0;
			fit_end <= '0;
			table_full <= 1'b0;
			interval_count <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WINDOW_START: window_start_q <= cfg_data;
					CFG_WINDOW_END: window_end_q <= cfg_data;
					CFG_MIN_FIT: min_fit_q <= cfg_data;
					default: min_fit_q <= min_fit_q;
				endcase
			end
			if (accept) begin
				rd_idx_q <= '0;
				wr_idx_q <= '0;
				proc_valid_s1 <= 1'b0;
				n_q <= cnt_q;
				ran_q <= (state_d == ST_RUN);
				claimed_q <= 1'b0;
				ok_q <= 1'b0;
				full_q <= 1'b0;
				found_q <= 1'b0;
				fstart_q <= '0;
				fend_q <= '0;
				req_q <= req_type;
				s_q <= range_start;
				e_q <= range_end;
				len_q <= claim_length;
				if (req_type == REQ_INIT) begin
					cnt_q <= CNT_W'(window_ok);
				end
			end else begin
				proc_valid_s1 <= issue;
				if (issue) begin
					proc_idx_s1 <= rd_idx_q;
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (wr_en) begin
					wr_idx_q <= wr_idx_q + 1'b1;
				end
			end
			if (split) begin
				pend_q <= '{ivl_start: e_q, ivl_stop: b};
			end
			if (set_ok) ok_q <= 1'b1;
			if (set_full) full_q <= 1'b1;
			if (set_claimed) claimed_q <= 1'b1;
			if (fit_hit) begin
				found_q <= 1'b1;
				fstart_q <= a;
				fend_q <= fend_sat;
			end
			if (state_q == ST_FINISH && state_d == ST_IDLE) begin
				out_valid <= 1'b1;
				claim_ok <= ok_q;
				fit_found <= found_q;
				fit_start <= fstart_q;
				fit_end <= fend_q;
				table_full <= full_q;
				interval_count <= cnt_next;
				cnt_q <= cnt_next;
				if (flip) begin
					bank_q <= !bank_q;
				end
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	`FIS_ASSERT_SAME(a_count_bound, 1'b1, cnt_q <= CNT_W'(MAX_INTERVALS))
	`FIS_ASSERT_SAME(a_read_bound, state_q == ST_RUN || state_q == ST_SPLIT2, rd_idx_q <= n_q)
	`FIS_ASSERT_SAME(a_result_kind, out_valid, !(claim_ok && fit_found))
	`FIS_ASSERT_NEXT(a_split_second, split, state_q == ST_SPLIT2)
endmodule

// ----- dv/tb_free_interval_set_top.sv -----
// Self-checking testbench for the free interval set: a predictor of the interval table checks every result beat.
module tb_free_interval_set_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fis_pkg::*;

	typedef struct packed {
		logic [1:0] req;
		logic [MIN_W-1:0] rs;
		logic [MIN_W-1:0] re;
		logic [MIN_W-1:0] len;
	} req_beat_t;

	typedef struct packed {
		logic ok;
		logic found;
		logic [MIN_W-1:0] fstart;
		logic [MIN_W-1:0] fend;
		logic full;
		logic [CNT_W-1:0] cnt;
	} resp_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_WINDOW_START;
	logic [MIN_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = REQ_INIT;
	logic [MIN_W-1:0] range_start = '0;
	logic [MIN_W-1:0] range_end = '0;
	logic [MIN_W-1:0] claim_length = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic claim_ok, fit_found, table_full;
	logic [MIN_W-1:0] fit_start, fit_end;
	logic [CNT_W-1:0] interval_count;

	free_interval_set_top i_dut (.*);

	always #5 clk = ~clk;

	// Predictor state.
	int unsigned win_lo = RST_WINDOW_START, win_hi = RST_WINDOW_END, min_len = RST_MIN_FIT;
	int unsigned lo_tab[MAX_INTERVALS], hi_tab[MAX_INTERVALS];
	int unsigned held;

	req_beat_t pending_reqs[$];
	resp_beat_t expected_resps[$];
	int send_idle_pct = 0, stall_pct = 0;
	int errors = 0;
	int sent = 0;
	int pushed = 0;
	longint cycles = 0;

	function automatic void reload_window();
		if (win_lo < win_hi) begin
			lo_tab[0] = win_lo;
			hi_tab[0] = win_hi;
			held = 1;
		end else begin
			held = 0;
		end
	endfunction

	function automatic void drop_entry(int unsigned i);
		for (int unsigned k = i; k + 1 < held; k++) begin
			lo_tab[k] = lo_tab[k+1];
			hi_tab[k] = hi_tab[k+1];
		end
		held--;
	endfunction

	function automatic void split_entry(int unsigned i, int unsigned s, int unsigned e);
		for (int unsigned k = held; k > i + 1; k--) begin
			lo_tab[k] = lo_tab[k-1];
			hi_tab[k] = hi_tab[k-1];
		end
		lo_tab[i+1] = e;
		hi_tab[i+1] = hi_tab[i];
		hi_tab[i] = s;
		held++;
	endfunction

	function automatic resp_beat_t serve_request(req_beat_t r);
		resp_beat_t o;
		int unsigned s, e, a, b, i, sum;
		o = '0;
		s = 32'(r.rs);
		e = 32'(r.re);
		case (r.req)
			REQ_INIT: reload_window();
			REQ_CLAIM: begin
				if (s < e) begin
					for (i = 0; i < held; i++) begin
						a = lo_tab[i];
						b = hi_tab[i];
						if (a <= s && e <= b) begin
							if (a == s && b == e) begin
								drop_entry(i);
								o.ok = 1'b1;
							end else if (a == s) begin
								lo_tab[i] = e;
								o.ok = 1'b1;
							end else if (b == e) begin
								hi_tab[i] = s;
								o.ok = 1'b1;
							end else if (held < MAX_INTERVALS) begin
								split_entry(i, s, e);
								o.ok = 1'b1;
							end else begin
								o.full = 1'b1;
							end
							break;
						end
					end
				end
			end
			REQ_SUB: begin
				if (s < e) begin
					i = 0;
					while (i < held) begin
						a = lo_tab[i];
						b = hi_tab[i];
						if (a < e && s < b) begin
							if (s <= a && b <= e) begin
								drop_entry(i);
								continue;
							end else if (s <= a) begin
								lo_tab[i] = e;
							end else if (b <= e) begin
								hi_tab[i] = s;
							end else if (held < MAX_INTERVALS) begin
								split_entry(i, s, e);
								i++;
							end else begin
								o.full = 1'b1;
							end
						end
						i++;
					end
				end
			end
			default: begin
				for (i = 0; i < held; i++) begin
					if (hi_tab[i] - lo_tab[i] >= min_len) begin
						sum = lo_tab[i] + 32'(r.len);
						o.found = 1'b1;
						o.fstart = MIN_W'(lo_tab[i]);
						o.fend = MIN_W'((sum > MINUTE_CAP) ? MINUTE_CAP : sum);
						break;
					end
				end
			end
		endcase
		o.cnt = CNT_W'(held);
		return o;
	endfunction

	// Driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req_beat_t r;
					r = pending_reqs.pop_front();
					in_valid <= 1'b1;
					req_type <= r.req;
					range_start <= r.rs;
					range_end <= r.re;
					claim_length <= r.len;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: predict on accepted requests, compare on accepted results.
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (in_valid && !in_stall) begin
				expected_resps.push_back(serve_request({req_type, range_start, range_end,
					claim_length}));
				sent++;
			end
			if (out_valid && !out_stall) begin
				if (expected_resps.size() == 0) begin
					$error("result beat with no request outstanding");
					errors++;
				end else begin
					resp_beat_t x;
					x = expected_resps.pop_front();
					if (claim_ok !== x.ok) begin
						$error("claim_ok exp %0d got %0d", x.ok, claim_ok); errors++;
					end
					if (fit_found !== x.found) begin
						$error("fit_found exp %0d got %0d", x.found, fit_found); errors++;
					end
					if (fit_start !== x.fstart) begin
						$error("fit_start exp %0d got %0d", x.fstart, fit_start); errors++;
					end
					if (fit_end !== x.fend) begin
						$error("fit_end exp %0d got %0d", x.fend, fit_end); errors++;
					end
					if (table_full !== x.full) begin
						$error("table_full exp %0d got %0d", x.full, table_full); errors++;
					end
					if (interval_count !== x.cnt) begin
						$error("interval_count exp %0d got %0d", x.cnt, interval_count);
						errors++;
					end
				end
			end
			if (cycles > 2000000) begin
				$display("** free_interval_set_top: FAILED **");
				$finish;
			end
		end
	end

	function automatic logic [MIN_W-1:0] pick_minute();
		case ($urandom_range(9))
			0: return MIN_W'($urandom_range(2047));
			1: return '0;
			2: return MIN_W'(MINUTE_CAP);
			default: return MIN_W'($urandom_range(MINUTE_CAP));
		endcase
	endfunction

	task automatic push_req(logic [1:0] rq, int s, int e, int l);
		pending_reqs.push_back({rq, MIN_W'(s), MIN_W'(e), MIN_W'(l)});
		pushed++;
	endtask

	task automatic drain();
		while (sent < pushed || expected_resps.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= MIN_W'(v);
		case (idx)
			CFG_WINDOW_START: win_lo = v;
			CFG_WINDOW_END: win_hi = v;
			default: min_len = v;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random mix of init, claim, subtract and query requests; most claims and subtracts are short ranges.
	task automatic random_phase(int n);
		int s, w;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0: push_req(REQ_INIT, pick_minute(), pick_minute(), pick_minute());
				1, 2, 3, 4: begin
					s = $urandom_range(MINUTE_CAP);
					w = $urandom_range(1, 30);
					push_req(REQ_CLAIM, s, s + w, pick_minute());
				end
				5: push_req(REQ_CLAIM, pick_minute(), pick_minute(), pick_minute());
				6, 7: begin
					s = $urandom_range(MINUTE_CAP);
					push_req(REQ_SUB, s, s + $urandom_range(1, 60), pick_minute());
				end
				default: push_req(REQ_QUERY, pick_minute(), pick_minute(), pick_minute());
			endcase
		end
	endtask

	initial begin
		reload_window();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: all request types, edge cases, and filling the table.
		push_req(REQ_QUERY, 0, 0, 0);
		push_req(REQ_QUERY, 0, 0, 2047);
		push_req(REQ_CLAIM, 600, 600, 0);
		push_req(REQ_CLAIM, 700, 600, 0);
		push_req(REQ_CLAIM, 510, 520, 0);
		push_req(REQ_CLAIM, 950, 960, 0);
		push_req(REQ_CLAIM, 600, 610, 0);
		push_req(REQ_CLAIM, 600, 610, 0);
		push_req(REQ_CLAIM, 520, 600, 0);
		push_req(REQ_SUB, 900, 800, 0);
		push_req(REQ_SUB, 0, 2047, 0);
		push_req(REQ_QUERY, 0, 0, 100);
		push_req(REQ_INIT, 2047, 2047, 2047);
		push_req(REQ_SUB, 700, 720, 0);
		push_req(REQ_QUERY, 0, 0, 1440);
		drain();

		write_reg(CFG_WINDOW_START, 0);
		write_reg(CFG_WINDOW_END, 1440);
		write_reg(CFG_MIN_FIT, 0);
		push_req(REQ_INIT, 0, 0, 0);
		for (int k = 0; k < 70; k++) push_req(REQ_CLAIM, 10 * k + 5, 10 * k + 6, 0);
		push_req(REQ_SUB, 1000, 1001, 0);
		push_req(REQ_QUERY, 0, 0, 5);
		drain();

		// Random phases with varying configuration and idling.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: begin send_idle_pct = 60; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 60; end
				3: begin send_idle_pct = 12; stall_pct = 12; end
				default: begin send_idle_pct = 0; stall_pct = 0; end
			endcase
			write_reg(CFG_WINDOW_START, (ph == 4) ? 1440 : $urandom_range(400));
			write_reg(CFG_WINDOW_END, (ph == 4) ? 0 : ((ph == 2) ? 2047 : $urandom_range(900, 1440)));
			write_reg(CFG_MIN_FIT, (ph == 3) ? 2047 : ((ph == 1) ? 1440 : $urandom_range(40)));
			push_req(REQ_INIT, 0, 0, 0);
			random_phase(80);
			drain();
		end
		write_reg(CFG_WINDOW_END, 1440);

		if (errors == 0) begin
			$display("** free_interval_set_top: PASSED **");
		end else begin
			$display("** free_interval_set_top: FAILED **");
		end
		$finish;
	end
endmodule
